/* rtl/core/sts_pkg.sv */
package sts_pkg;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       final_byte;
	} src_word_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic [7:0]  operator_byte;
		logic [16:0] error_line;
		logic [15:0] error_column;
		logic        last_result;
	} tok_word_t;

	// up to two records made by one source byte, in stream order
	typedef struct packed {
		logic [1:0] count;
		tok_word_t  first;
		tok_word_t  second;
	} tok_push_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] kind;
	} punct_t;

	localparam logic [3:0] KIND_PAREN_OPEN   = 4'd0;
	localparam logic [3:0] KIND_PAREN_CLOSE  = 4'd1;
	localparam logic [3:0] KIND_BRACE_OPEN   = 4'd2;
	localparam logic [3:0] KIND_BRACE_CLOSE  = 4'd3;
	localparam logic [3:0] KIND_BRACKET_OPEN = 4'd4;
	localparam logic [3:0] KIND_BRACKET_CLOSE = 4'd5;
	localparam logic [3:0] KIND_COMMA        = 4'd6;
	localparam logic [3:0] KIND_SEMICOLON    = 4'd7;
	localparam logic [3:0] KIND_NEWLINE      = 4'd8;
	localparam logic [3:0] KIND_OPERATOR     = 4'd9;
	localparam logic [3:0] KIND_STRING       = 4'd10;
	localparam logic [3:0] KIND_IDENT        = 4'd11;
	localparam logic [3:0] KIND_NUMBER       = 4'd12;
	localparam logic [3:0] KIND_DOT          = 4'd13;
	localparam logic [3:0] KIND_ERROR        = 4'd14;
	localparam logic [3:0] KIND_END          = 4'd15;

	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHAR_TAB       = 8'h09;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;
	localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
	localparam logic [7:0] CHAR_BACKTICK  = 8'h60;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
	localparam logic [7:0] CHAR_DOT       = 8'h2E;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha_sym(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			(c == CHAR_UNDERSCORE) || (c == CHAR_DOLLAR);
	endfunction

	function automatic logic is_operator(input logic [7:0] c);
		logic hit;
		case (c)
			8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h5E, 8'h26, 8'h7C,
			8'h7E, 8'h21, 8'h3D, 8'h3C, 8'h3E, 8'h3F, 8'h3A: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic punct_t punct_kind(input logic [7:0] c);
		punct_t r;
		r.hit = 1'b1;
		case (c)
			8'h28: r.kind = KIND_PAREN_OPEN;
			8'h29: r.kind = KIND_PAREN_CLOSE;
			8'h7B: r.kind = KIND_BRACE_OPEN;
			8'h7D: r.kind = KIND_BRACE_CLOSE;
			8'h5B: r.kind = KIND_BRACKET_OPEN;
			8'h5D: r.kind = KIND_BRACKET_CLOSE;
			8'h2C: r.kind = KIND_COMMA;
			8'h3B: r.kind = KIND_SEMICOLON;
			default: begin
				r.hit = 1'b0;
				r.kind = KIND_PAREN_OPEN;
			end
		endcase
		return r;
	endfunction

	function automatic tok_word_t make_tok(input logic [3:0] kind, input logic [15:0] start,
			input logic [15:0] len, input logic [7:0] op, input logic [16:0] eline,
			input logic [15:0] ecol);
		tok_word_t t;
		t.token_kind = kind;
		t.token_start = start;
		t.token_length = len;
		t.operator_byte = op;
		t.error_line = eline;
		t.error_column = ecol;
		t.last_result = 1'b0;
		return t;
	endfunction

endpackage

/* rtl/core/sts_scan.sv */
module sts_scan #(
	parameter int MAX_SOURCE_BYTES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  sts_pkg::src_word_t  src_word,
	input  logic                room,
	output sts_pkg::tok_push_t  push
);

	localparam int PW = $clog2(MAX_SOURCE_BYTES);
	localparam logic [PW:0] MAX_W = (PW + 1)'(MAX_SOURCE_BYTES);
	localparam logic [PW-1:0] LAST_POS = PW'(MAX_SOURCE_BYTES - 1);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_STRING
	} mode_t;

	function automatic logic [PW-1:0] pos_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (a < b)
			d = d + MAX_W;
		return d[PW-1:0];
	endfunction

	function automatic logic [15:0] fit16(input logic [PW:0] v);
		logic [PW+16:0] w;
		w = {16'b0, v};
		return w[15:0];
	endfunction

	// input register
	logic               valid_s1;
	sts_pkg::src_word_t word_s1;

	// scanner state
	mode_t         mode_q, mode_d;
	logic          backtick_q, backtick_d;
	logic          escape_q, escape_d;
	logic          dot_q, dot_d;
	logic [PW-1:0] start_q, start_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [16:0]   line_q, line_d;
	logic [PW-1:0] nl_pos_q, nl_pos_d;
	logic          halted_q, halted_d;
	logic [16:0]   quote_line_q, quote_line_d;
	logic [15:0]   quote_col_q, quote_col_d;

	logic               step;
	sts_pkg::tok_push_t push_d;

	assign src_stall = valid_s1 && !room;
	assign step = valid_s1 && room;

	always_comb begin
		logic [7:0]        c;
		logic              fin;
		logic              consumed;
		logic              a_v, b_v, c_v;
		sts_pkg::tok_word_t a_t, b_t, c_t, first, second;
		sts_pkg::punct_t   pk;
		logic [1:0]        cnt;
		logic [3:0]        run_kind;

		c = word_s1.source_byte;
		fin = word_s1.final_byte;
		pk = sts_pkg::punct_kind(c);
		consumed = 1'b0;
		a_v = 1'b0;
		b_v = 1'b0;
		c_v = 1'b0;
		a_t = '0;
		b_t = '0;
		c_t = '0;
		run_kind = (mode_q == MODE_IDENT) ? sts_pkg::KIND_IDENT : sts_pkg::KIND_NUMBER;

		mode_d = mode_q;
		backtick_d = backtick_q;
		escape_d = escape_q;
		dot_d = dot_q;
		start_d = start_q;
		pos_d = pos_q;
		line_d = line_q;
		nl_pos_d = nl_pos_q;
		halted_d = halted_q;
		quote_line_d = quote_line_q;
		quote_col_d = quote_col_q;

		if (!halted_q) begin
			if (mode_q == MODE_STRING) begin
				if (!backtick_q && c == sts_pkg::CHAR_NEWLINE) begin
					a_v = 1'b1;
					a_t = sts_pkg::make_tok(sts_pkg::KIND_ERROR, fit16({1'b0, start_q}), 16'd0,
						8'd0, quote_line_q, quote_col_q);
					halted_d = 1'b1;
					mode_d = MODE_IDLE;
					escape_d = 1'b0;
				end else if (escape_q) begin
					escape_d = 1'b0;
				end else if (c == sts_pkg::CHAR_BACKSLASH) begin
					escape_d = 1'b1;
				end else if (c == (backtick_q ? sts_pkg::CHAR_BACKTICK : sts_pkg::CHAR_DQUOTE)) begin
					a_v = 1'b1;
					a_t = sts_pkg::make_tok(sts_pkg::KIND_STRING, fit16({1'b0, start_q}),
						fit16({1'b0, pos_diff(pos_q, start_q)}), 8'd0, 17'd0, 16'd0);
					mode_d = MODE_IDLE;
				end
			end else begin
				if (mode_q == MODE_IDENT || mode_q == MODE_NUMBER) begin
					if (sts_pkg::is_alpha_sym(c) || sts_pkg::is_digit(c) ||
							(mode_q == MODE_NUMBER && c == sts_pkg::CHAR_DOT)) begin
						consumed = 1'b1;
					end else begin
						a_v = 1'b1;
						a_t = sts_pkg::make_tok(run_kind, fit16({1'b0, start_q}),
							fit16({1'b0, pos_diff(pos_q, start_q)}), 8'd0, 17'd0, 16'd0);
						mode_d = MODE_IDLE;
					end
				end else if (dot_q) begin
					dot_d = 1'b0;
					if (sts_pkg::is_digit(c)) begin
						mode_d = MODE_NUMBER;
						consumed = 1'b1;
					end else begin
						a_v = 1'b1;
						a_t = sts_pkg::make_tok(sts_pkg::KIND_DOT, fit16({1'b0, start_q}),
							16'd1, 8'd0, 17'd0, 16'd0);
					end
				end
				// byte seen between tokens
				if (!consumed && c != sts_pkg::CHAR_SPACE && c != sts_pkg::CHAR_TAB) begin
					if (pk.hit) begin
						b_v = 1'b1;
						b_t = sts_pkg::make_tok(pk.kind, fit16({1'b0, pos_q}), 16'd1, 8'd0,
							17'd0, 16'd0);
					end else if (c == sts_pkg::CHAR_NEWLINE) begin
						b_v = 1'b1;
						b_t = sts_pkg::make_tok(sts_pkg::KIND_NEWLINE, fit16({1'b0, pos_q}), 16'd1,
							8'd0, 17'd0, 16'd0);
					end else if (sts_pkg::is_operator(c)) begin
						b_v = 1'b1;
						b_t = sts_pkg::make_tok(sts_pkg::KIND_OPERATOR, fit16({1'b0, pos_q}),
							16'd1, c, 17'd0, 16'd0);
					end else if (c == sts_pkg::CHAR_DQUOTE || c == sts_pkg::CHAR_BACKTICK) begin
						mode_d = MODE_STRING;
						backtick_d = (c == sts_pkg::CHAR_BACKTICK);
						escape_d = 1'b0;
						start_d = (pos_q == LAST_POS) ? '0 : pos_q + PW'(1);
						quote_line_d = line_q;
						quote_col_d = fit16({1'b0, pos_diff(pos_q, nl_pos_q)});
					end else if (sts_pkg::is_alpha_sym(c)) begin
						mode_d = MODE_IDENT;
						start_d = pos_q;
					end else if (sts_pkg::is_digit(c)) begin
						mode_d = MODE_NUMBER;
						start_d = pos_q;
					end else if (c == sts_pkg::CHAR_DOT) begin
						dot_d = 1'b1;
						start_d = pos_q;
					end
				end
			end
			if (c == sts_pkg::CHAR_NEWLINE) begin
				line_d = line_q + 17'd1;
				nl_pos_d = pos_q;
			end
		end

		if (fin) begin
			// close whatever is still open at the end of the stream
			if (!halted_d) begin
				if (mode_d == MODE_IDENT || mode_d == MODE_NUMBER) begin
					c_v = 1'b1;
					c_t = sts_pkg::make_tok(
						(mode_d == MODE_IDENT) ? sts_pkg::KIND_IDENT : sts_pkg::KIND_NUMBER,
						fit16({1'b0, start_d}),
						fit16({1'b0, pos_diff(pos_q, start_d)} + (PW + 1)'(1)),
						8'd0, 17'd0, 16'd0);
				end else if (mode_d == MODE_STRING) begin
					c_v = 1'b1;
					c_t = sts_pkg::make_tok(sts_pkg::KIND_ERROR, fit16({1'b0, start_d}), 16'd0,
						8'd0, quote_line_d, quote_col_d);
				end else if (dot_d) begin
					c_v = 1'b1;
					c_t = sts_pkg::make_tok(sts_pkg::KIND_DOT, fit16({1'b0, start_d}), 16'd1,
						8'd0, 17'd0, 16'd0);
				end
			end
			if (!a_v && !b_v && !c_v) begin
				c_v = 1'b1;
				c_t = sts_pkg::make_tok(sts_pkg::KIND_END, 16'd0, 16'd0, 8'd0, 17'd0, 16'd0);
			end
			mode_d = MODE_IDLE;
			backtick_d = 1'b0;
			escape_d = 1'b0;
			dot_d = 1'b0;
			start_d = '0;
			pos_d = '0;
			line_d = 17'd1;
			nl_pos_d = '0;
			halted_d = 1'b0;
			quote_line_d = 17'd0;
			quote_col_d = 16'd0;
		end else begin
			pos_d = (pos_q == LAST_POS) ? '0 : pos_q + PW'(1);
		end

		// pack the records in stream order; at most two are ever present
		first = a_v ? a_t : (b_v ? b_t : c_t);
		second = (a_v && b_v) ? b_t : c_t;
		cnt = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
		if (fin) begin
			if (cnt == 2'd1)
				first.last_result = 1'b1;
			else
				second.last_result = 1'b1;
		end
		push_d.count = step ? cnt : 2'd0;
		push_d.first = first;
		push_d.second = second;
	end

	assign push = push_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= MODE_IDLE;
			backtick_q <= 1'b0;
			escape_q <= 1'b0;
			dot_q <= 1'b0;
			start_q <= '0;
			pos_q <= '0;
			line_q <= 17'd1;
			nl_pos_q <= '0;
			halted_q <= 1'b0;
			quote_line_q <= 17'd0;
			quote_col_q <= 16'd0;
		end else begin
			if (src_valid && !src_stall)
				valid_s1 <= 1'b1;
			else if (step)
				valid_s1 <= 1'b0;
			if (step) begin
				mode_q <= mode_d;
				backtick_q <= backtick_d;
				escape_q <= escape_d;
				dot_q <= dot_d;
				start_q <= start_d;
				pos_q <= pos_d;
				line_q <= line_d;
				nl_pos_q <= nl_pos_d;
				halted_q <= halted_d;
				quote_line_q <= quote_line_d;
				quote_col_q <= quote_col_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall)
			word_s1 <= src_word;
	end

endmodule

/* rtl/core/sts_fifo.sv */
module sts_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  sts_pkg::tok_push_t push,
	output logic               room,
	output logic               tok_valid,
	input  logic               tok_stall,
	output sts_pkg::tok_word_t tok_word
);

	sts_pkg::tok_word_t mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;
	logic       pop;

	// room for the two records one byte can make
	assign room = (count_q <= 3'd2);
	assign tok_valid = (count_q != 3'd0);
	assign tok_word = mem_q[rd_q];
	assign pop = tok_valid && !tok_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 2'd0;
			rd_q <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wr_q <= wr_q + push.count;
			if (pop)
				rd_q <= rd_q + 2'd1;
			count_q <= count_q + {1'b0, push.count} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[wr_q + 2'd1] <= push.second;
	end

endmodule

/* rtl/core/script_token_scanner_unit.sv */
// Streaming source tokenizer. Source bytes arrive one word per handshake on the
// src channel and token records leave one word per handshake on the tok channel.
// Each byte is registered, then classified and folded into the scan state, so a
// new byte is taken every cycle while the result queue has room; a byte may close
// one token and start or emit another, so it yields zero, one or two records,
// which wait in a four-entry result queue. The src side stalls only while that
// queue holds more than two records. Positions count modulo MAX_SOURCE_BYTES;
// after the word marked final_byte the scanner returns to its reset state for
// the next stream, and the final record of a stream carries last_result.
module script_token_scanner_unit #(
	parameter int MAX_SOURCE_BYTES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  sts_pkg::src_word_t src_word,
	output logic               tok_valid,
	input  logic               tok_stall,
	output sts_pkg::tok_word_t tok_word
);

	sts_pkg::tok_push_t push;
	logic               room;

	sts_scan #(
		.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word(src_word),
		.room(room),
		.push(push)
	);

	sts_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_word(tok_word)
	);

endmodule

/* tb/sv/tb_script_token_scanner_unit.sv */
module tb_script_token_scanner_unit;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_PHASE_BYTES = 160;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_IDENT,
		SCAN_NUMBER,
		SCAN_STRING
	} scan_state_t;

	// n_typed < 0 means the row is checked against the predictor
	typedef struct packed {
		sts_pkg::src_word_t w;
		int                 n_typed;
		sts_pkg::tok_word_t t0;
		sts_pkg::tok_word_t t1;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_stall;
	sts_pkg::src_word_t src_word = '0;
	logic               tok_valid;
	logic               tok_stall = 1'b0;
	sts_pkg::tok_word_t tok_word;

	script_token_scanner_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word(src_word),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_word(tok_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scanner state as the predictor sees it
	scan_state_t sc_mode;
	logic        sc_backtick, sc_escape, sc_dot, sc_halted;
	logic [15:0] sc_start, sc_pos, sc_nl_pos, sc_qcol;
	logic [16:0] sc_line, sc_qline;

	sts_pkg::tok_word_t step_recs[$];
	sts_pkg::tok_word_t pending_tokens[$];
	stim_row_t          directed_rows[$];
	logic [7:0]         src_text[$];

	int          src_idle_pct = 0;
	int          tok_stall_pct = 0;
	int          hold_asked = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          fail_count = 0;
	int          bytes_sent = 0;
	int          live_bytes = 0;
	int          streams_sent = 0;
	int          records_checked = 0;
	int          error_records = 0;
	logic [15:0] kinds_seen = '0;

	string       id_first = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$";
	string       id_rest = "azAZ09_$xQ7";
	string       digits = "0123456789";
	string       num_rest = "0123456789.eEx_";
	string       punct_chars = "(){}[],;";
	string       op_chars = "+-*/%^&|~!=<>?:";
	string       str_body = "abcxyzABC019 +-(){};.,_$#@!'";

	function automatic logic [7:0] pick(input string chars);
		return chars[$urandom_range(chars.len() - 1)];
	endfunction

	function automatic sts_pkg::tok_word_t token_rec(input logic [3:0] kind,
			input logic [15:0] start, input logic [15:0] len, input logic [7:0] op,
			input logic [16:0] eline, input logic [15:0] ecol, input logic last);
		sts_pkg::tok_word_t t;
		t.token_kind = kind;
		t.token_start = start;
		t.token_length = len;
		t.operator_byte = op;
		t.error_line = eline;
		t.error_column = ecol;
		t.last_result = last;
		return t;
	endfunction

	function automatic void add_rec(input logic [3:0] kind, input logic [15:0] start,
			input logic [15:0] len, input logic [7:0] op, input logic [16:0] eline,
			input logic [15:0] ecol);
		step_recs.push_back(token_rec(kind, start, len, op, eline, ecol, 1'b0));
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic word_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			c == sts_pkg::CHAR_UNDERSCORE || c == sts_pkg::CHAR_DOLLAR;
	endfunction

	function automatic logic op_char(input logic [7:0] c);
		case (c)
			"+", "-", "*", "/", "%", "^", "&", "|", "~", "!", "=", "<", ">", "?", ":":
				return 1'b1;
			default:
				return 1'b0;
		endcase
	endfunction

	function automatic logic punct_code(input logic [7:0] c, output logic [3:0] k);
		logic hit;
		hit = 1'b1;
		case (c)
			"(": k = sts_pkg::KIND_PAREN_OPEN;
			")": k = sts_pkg::KIND_PAREN_CLOSE;
			"{": k = sts_pkg::KIND_BRACE_OPEN;
			"}": k = sts_pkg::KIND_BRACE_CLOSE;
			"[": k = sts_pkg::KIND_BRACKET_OPEN;
			"]": k = sts_pkg::KIND_BRACKET_CLOSE;
			",": k = sts_pkg::KIND_COMMA;
			";": k = sts_pkg::KIND_SEMICOLON;
			default: begin
				k = sts_pkg::KIND_PAREN_OPEN;
				hit = 1'b0;
			end
		endcase
		return hit;
	endfunction

	function automatic void scanner_clear();
		sc_mode = SCAN_IDLE;
		sc_backtick = 1'b0;
		sc_escape = 1'b0;
		sc_dot = 1'b0;
		sc_halted = 1'b0;
		sc_start = '0;
		sc_pos = '0;
		sc_nl_pos = '0;
		sc_qcol = '0;
		sc_line = 17'd1;
		sc_qline = '0;
	endfunction

	function automatic void string_error();
		add_rec(sts_pkg::KIND_ERROR, sc_start, '0, '0, sc_qline, sc_qcol);
		sc_halted = 1'b1;
		sc_mode = SCAN_IDLE;
		sc_escape = 1'b0;
	endfunction

	// advances the scanner by one source byte, leaving its records in step_recs
	function automatic void tokenize_byte(input sts_pkg::src_word_t w);
		logic [7:0]  c;
		logic [15:0] p;
		logic [3:0]  pk;
		logic        taken;
		c = w.source_byte;
		p = sc_pos;
		taken = 1'b0;
		step_recs.delete();
		if (!sc_halted) begin
			if (sc_mode == SCAN_STRING) begin
				// a newline ends a double-quoted string in error, escaped or not
				if (!sc_backtick && c == sts_pkg::CHAR_NEWLINE) begin
					string_error();
				end else if (sc_escape) begin
					sc_escape = 1'b0;
				end else if (c == sts_pkg::CHAR_BACKSLASH) begin
					sc_escape = 1'b1;
				end else if (c == (sc_backtick ? sts_pkg::CHAR_BACKTICK : sts_pkg::CHAR_DQUOTE)) begin
					add_rec(sts_pkg::KIND_STRING, sc_start, p - sc_start, '0, '0, '0);
					sc_mode = SCAN_IDLE;
				end
			end else begin
				if (sc_mode == SCAN_IDENT || sc_mode == SCAN_NUMBER) begin
					if (word_char(c) || digit_char(c) ||
							(sc_mode == SCAN_NUMBER && c == sts_pkg::CHAR_DOT)) begin
						taken = 1'b1;
					end else begin
						add_rec(sc_mode == SCAN_IDENT ? sts_pkg::KIND_IDENT : sts_pkg::KIND_NUMBER,
							sc_start, p - sc_start, '0, '0, '0);
						sc_mode = SCAN_IDLE;
					end
				end else if (sc_dot) begin
					sc_dot = 1'b0;
					if (digit_char(c)) begin
						sc_mode = SCAN_NUMBER;
						taken = 1'b1;
					end else begin
						add_rec(sts_pkg::KIND_DOT, sc_start, 16'd1, '0, '0, '0);
					end
				end
				if (!taken && c != sts_pkg::CHAR_SPACE && c != sts_pkg::CHAR_TAB) begin
					if (punct_code(c, pk)) begin
						add_rec(pk, p, 16'd1, '0, '0, '0);
					end else if (c == sts_pkg::CHAR_NEWLINE) begin
						add_rec(sts_pkg::KIND_NEWLINE, p, 16'd1, '0, '0, '0);
					end else if (op_char(c)) begin
						add_rec(sts_pkg::KIND_OPERATOR, p, 16'd1, c, '0, '0);
					end else if (c == sts_pkg::CHAR_DQUOTE || c == sts_pkg::CHAR_BACKTICK) begin
						sc_mode = SCAN_STRING;
						sc_backtick = (c == sts_pkg::CHAR_BACKTICK);
						sc_escape = 1'b0;
						sc_start = p + 16'd1;
						sc_qline = sc_line;
						sc_qcol = p - sc_nl_pos;
					end else if (word_char(c)) begin
						sc_mode = SCAN_IDENT;
						sc_start = p;
					end else if (digit_char(c)) begin
						sc_mode = SCAN_NUMBER;
						sc_start = p;
					end else if (c == sts_pkg::CHAR_DOT) begin
						sc_dot = 1'b1;
						sc_start = p;
					end
				end
			end
			if (c == sts_pkg::CHAR_NEWLINE) begin
				sc_line = sc_line + 17'd1;
				sc_nl_pos = p;
			end
		end
		if (w.final_byte) begin
			if (!sc_halted) begin
				if (sc_mode == SCAN_IDENT || sc_mode == SCAN_NUMBER) begin
					add_rec(sc_mode == SCAN_IDENT ? sts_pkg::KIND_IDENT : sts_pkg::KIND_NUMBER,
						sc_start, p - sc_start + 16'd1, '0, '0, '0);
				end else if (sc_mode == SCAN_STRING) begin
					string_error();
				end else if (sc_dot) begin
					add_rec(sts_pkg::KIND_DOT, sc_start, 16'd1, '0, '0, '0);
				end
			end
			if (step_recs.size() == 0) begin
				add_rec(sts_pkg::KIND_END, '0, '0, '0, '0, '0);
			end
			step_recs[step_recs.size() - 1].last_result = 1'b1;
			scanner_clear();
		end else begin
			sc_pos = p + 16'd1;
		end
	endfunction

	function automatic void add_row(input logic [7:0] b, input logic fin, input int n,
			input sts_pkg::tok_word_t t0, input sts_pkg::tok_word_t t1);
		stim_row_t r;
		r.w.source_byte = b;
		r.w.final_byte = fin;
		r.n_typed = n;
		r.t0 = t0;
		r.t1 = t1;
		directed_rows.push_back(r);
	endfunction

	function automatic void build_directed();
		// every punctuation byte, whitespace, newline, an operator, dropped extremes
		add_row("(", 1'b0, 1, token_rec(sts_pkg::KIND_PAREN_OPEN, 0, 1, 0, 0, 0, 0), '0);
		add_row(")", 1'b0, 1, token_rec(sts_pkg::KIND_PAREN_CLOSE, 1, 1, 0, 0, 0, 0), '0);
		add_row("{", 1'b0, 1, token_rec(sts_pkg::KIND_BRACE_OPEN, 2, 1, 0, 0, 0, 0), '0);
		add_row("}", 1'b0, 1, token_rec(sts_pkg::KIND_BRACE_CLOSE, 3, 1, 0, 0, 0, 0), '0);
		add_row("[", 1'b0, 1, token_rec(sts_pkg::KIND_BRACKET_OPEN, 4, 1, 0, 0, 0, 0), '0);
		add_row("]", 1'b0, 1, token_rec(sts_pkg::KIND_BRACKET_CLOSE, 5, 1, 0, 0, 0, 0), '0);
		add_row(",", 1'b0, 1, token_rec(sts_pkg::KIND_COMMA, 6, 1, 0, 0, 0, 0), '0);
		add_row(";", 1'b0, 1, token_rec(sts_pkg::KIND_SEMICOLON, 7, 1, 0, 0, 0, 0), '0);
		add_row(sts_pkg::CHAR_SPACE, 1'b0, 0, '0, '0);
		add_row(sts_pkg::CHAR_TAB, 1'b0, 0, '0, '0);
		add_row(sts_pkg::CHAR_NEWLINE, 1'b0, 1,
			token_rec(sts_pkg::KIND_NEWLINE, 10, 1, 0, 0, 0, 0), '0);
		add_row("+", 1'b0, 1, token_rec(sts_pkg::KIND_OPERATOR, 11, 1, "+", 0, 0, 0), '0);
		add_row(8'h00, 1'b0, 0, '0, '0);
		add_row(8'hFF, 1'b0, 0, '0, '0);
		// identifier cut by a dot, dot plus digit starting a number
		add_row("x", 1'b0, -1, '0, '0);
		add_row(sts_pkg::CHAR_DOT, 1'b0, 1, token_rec(sts_pkg::KIND_IDENT, 14, 1, 0, 0, 0, 0), '0);
		add_row("5", 1'b0, -1, '0, '0);
		add_row(sts_pkg::CHAR_DQUOTE, 1'b0, 1,
			token_rec(sts_pkg::KIND_NUMBER, 15, 2, 0, 0, 0, 0), '0);
		// escaped newline still breaks a double-quoted string
		add_row(sts_pkg::CHAR_BACKSLASH, 1'b0, -1, '0, '0);
		add_row(sts_pkg::CHAR_NEWLINE, 1'b0, 1,
			token_rec(sts_pkg::KIND_ERROR, 18, 0, 0, 2, 7, 0), '0);
		add_row("a", 1'b0, 0, '0, '0);
		add_row("b", 1'b1, 1, token_rec(sts_pkg::KIND_END, 0, 0, 0, 0, 0, 1), '0);
		// backtick string over a line, doubled backslash, dot left at the end
		add_row(sts_pkg::CHAR_BACKTICK, 1'b0, -1, '0, '0);
		add_row(sts_pkg::CHAR_NEWLINE, 1'b0, -1, '0, '0);
		add_row(sts_pkg::CHAR_BACKSLASH, 1'b0, -1, '0, '0);
		add_row(sts_pkg::CHAR_BACKSLASH, 1'b0, -1, '0, '0);
		add_row(sts_pkg::CHAR_BACKTICK, 1'b0, 1,
			token_rec(sts_pkg::KIND_STRING, 1, 3, 0, 0, 0, 0), '0);
		add_row(sts_pkg::CHAR_DOT, 1'b1, 1, token_rec(sts_pkg::KIND_DOT, 5, 1, 0, 0, 0, 1), '0);
		// stream ends inside a string, then one ending inside an identifier
		add_row(sts_pkg::CHAR_DQUOTE, 1'b1, 1,
			token_rec(sts_pkg::KIND_ERROR, 1, 0, 0, 1, 0, 1), '0);
		add_row("z", 1'b1, 1, token_rec(sts_pkg::KIND_IDENT, 0, 1, 0, 0, 0, 1), '0);
	endfunction

	function automatic void gen_quoted();
		logic [7:0] q;
		q = $urandom_range(1) ? sts_pkg::CHAR_BACKTICK : sts_pkg::CHAR_DQUOTE;
		src_text.push_back(q);
		repeat ($urandom_range(6)) begin
			case ($urandom_range(7))
				0: begin
					src_text.push_back(sts_pkg::CHAR_BACKSLASH);
					case ($urandom_range(2))
						0: src_text.push_back(q);
						1: src_text.push_back(sts_pkg::CHAR_BACKSLASH);
						default: src_text.push_back(8'($urandom_range(255)));
					endcase
				end
				1: src_text.push_back(q == sts_pkg::CHAR_BACKTICK ? sts_pkg::CHAR_NEWLINE :
					pick(str_body));
				default: src_text.push_back(pick(str_body));
			endcase
		end
		// now and then the string is left open or broken by a bare newline
		case ($urandom_range(24))
			0: ;
			1: src_text.push_back(sts_pkg::CHAR_NEWLINE);
			default: src_text.push_back(q);
		endcase
	endfunction

	function automatic void gen_stream(input int n_tok);
		src_text.delete();
		repeat (n_tok) begin
			case ($urandom_range(15))
				0, 1: begin
					src_text.push_back(pick(id_first));
					repeat ($urandom_range(6)) src_text.push_back(pick(id_rest));
				end
				2, 3: begin
					if ($urandom_range(3) == 0) src_text.push_back(sts_pkg::CHAR_DOT);
					src_text.push_back(pick(digits));
					repeat ($urandom_range(5)) src_text.push_back(pick(num_rest));
				end
				4, 5: gen_quoted();
				6: src_text.push_back(pick(punct_chars));
				7, 8: src_text.push_back(pick(op_chars));
				9: src_text.push_back($urandom_range(1) ? sts_pkg::CHAR_SPACE : sts_pkg::CHAR_TAB);
				10: src_text.push_back(sts_pkg::CHAR_NEWLINE);
				11: src_text.push_back(sts_pkg::CHAR_DOT);
				12: src_text.push_back(8'($urandom_range(255)));
				13: src_text.push_back(8'($urandom_range(255, 128)));
				default: src_text.push_back(8'($urandom_range(31)));
			endcase
		end
	endfunction

	task automatic send_byte(input sts_pkg::src_word_t w, input int n_typed,
			input sts_pkg::tok_word_t t0, input sts_pkg::tok_word_t t1);
		logic was_halted;
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_word <= w;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		was_halted = sc_halted;
		tokenize_byte(w);
		if (n_typed < 0) begin
			foreach (step_recs[i]) pending_tokens.push_back(step_recs[i]);
		end else begin
			if (n_typed > 0) pending_tokens.push_back(t0);
			if (n_typed > 1) pending_tokens.push_back(t1);
		end
		foreach (step_recs[i]) begin
			kinds_seen[step_recs[i].token_kind] = 1'b1;
			if (step_recs[i].token_kind == sts_pkg::KIND_ERROR) error_records++;
		end
		bytes_sent++;
		if (!was_halted) live_bytes++;
	endtask

	task automatic send_text();
		sts_pkg::src_word_t w;
		for (int i = 0; i < src_text.size(); i++) begin
			w.source_byte = src_text[i];
			w.final_byte = (i == src_text.size() - 1);
			send_byte(w, -1, '0, '0);
		end
		streams_sent++;
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		@(posedge clk);
		while (pending_tokens.size() != 0) @(posedge clk);
	endtask

	task automatic run_random(input int src_pct, input int tok_pct, input int n_bytes,
			input bit with_hold);
		int first;
		src_idle_pct = src_pct;
		tok_stall_pct = tok_pct;
		first = live_bytes;
		while (live_bytes - first < n_bytes) begin
			gen_stream($urandom_range(14, 1));
			send_text();
			if (with_hold && live_bytes - first > n_bytes / 3) begin
				// every byte here makes a record, so the result queue backs up
				with_hold = 1'b0;
				hold_asked++;
				src_text.delete();
				repeat (24) src_text.push_back(pick(punct_chars));
				send_text();
			end
		end
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			tok_stall <= 1'b1;
		end else begin
			tok_stall <= ($urandom_range(99) < tok_stall_pct);
		end
	end

	function automatic void cmp_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : tok_check
		sts_pkg::tok_word_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (pending_tokens.size() == 0) begin
				$error("token word with nothing pending: token_kind %0d token_start %0d",
					tok_word.token_kind, tok_word.token_start);
				fail_count++;
			end else begin
				want = pending_tokens.pop_front();
				records_checked++;
				cmp_field("token_kind", want.token_kind, tok_word.token_kind);
				cmp_field("token_start", want.token_start, tok_word.token_start);
				cmp_field("token_length", want.token_length, tok_word.token_length);
				cmp_field("operator_byte", want.operator_byte, tok_word.operator_byte);
				cmp_field("error_line", want.error_line, tok_word.error_line);
				cmp_field("error_column", want.error_column, tok_word.error_column);
				cmp_field("last_result", want.last_result, tok_word.last_result);
			end
		end
	end

	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (tok_valid && !tok_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		scanner_clear();
		build_directed();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].w, directed_rows[i].n_typed, directed_rows[i].t0,
				directed_rows[i].t1);
		end
		streams_sent += 4;
		drain();

		run_random(0, 0, RANDOM_PHASE_BYTES, 1'b1);
		run_random(50, 0, RANDOM_PHASE_BYTES, 1'b0);
		run_random(0, 50, RANDOM_PHASE_BYTES, 1'b0);
		run_random(37, 37, RANDOM_PHASE_BYTES, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_tokens.size() != 0) begin
			$error("%0d token words never arrived", pending_tokens.size());
			fail_count++;
		end

		$display("scanned %0d source bytes in %0d streams under four idle/stall mixes",
			bytes_sent, streams_sent);
		$display("checked %0d token words, %0d of 16 kinds, %0d string errors",
			records_checked, $countones(kinds_seen), error_records);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
